[rtl/spq_pkg.sv]
package spq_pkg;

  localparam int CAPACITY   = 32;
  localparam int COORD_BITS = 16;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int STAT_W     = 2;
  localparam int COUNT_W    = 6;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DUP   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  typedef struct packed {
    logic                         operation;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]            status;
    logic signed [COORD_BITS-1:0] popped_x;
    logic signed [COORD_BITS-1:0] popped_y;
    logic signed [COORD_BITS-1:0] top_x;
    logic signed [COORD_BITS-1:0] top_y;
    logic [COUNT_W-1:0]           stored_count;
    logic                         is_empty;
  } out_word_t;

  // control broadcast to every cell
  typedef struct packed {
    logic   cmp_en;
    logic   ins;
    logic   shift;
    point_t pnt;
  } cell_ctl_t;

endpackage

[rtl/spq_cell.sv]
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic              slot_valid,
  input  spq_pkg::point_t   left_pt,
  input  logic              left_ge,
  input  spq_pkg::point_t   right_pt,
  output spq_pkg::point_t   pt,
  output logic              ge,
  output logic              eq
);

  spq_pkg::point_t pt_r;
  logic            gt_r;
  logic            eq_r;
  logic            gt_nxt;

  // lexicographic compare: x first, then y
  always_comb begin
    gt_nxt = (pt_r.x > ctl.pnt.x) || ((pt_r.x == ctl.pnt.x) && (pt_r.y > ctl.pnt.y));
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      gt_r <= gt_nxt;
      eq_r <= (pt_r == ctl.pnt);
    end
    if (ctl.ins && ge) begin
      pt_r <= left_ge ? left_pt : ctl.pnt;
    end else if (ctl.shift) begin
      pt_r <= right_pt;
    end
  end

  // an empty slot counts as greater so the insert point lands at the tail
  assign ge = !slot_valid || gt_r;
  assign eq = slot_valid && eq_r;
  assign pt = pt_r;

endmodule

[rtl/sorted_point_priority_queue_core.sv]
// channel | ports                  | handshake
// --------+------------------------+------------------------------------
// input   | in_word, start, busy   | word taken when start && !busy
// result  | out_word, out_valid    | one-cycle strobe, no back-pressure
//
// a taken word steps through S_CMP, which compares it in every cell, S_UPD,
// which inserts/shifts across the cell row, and S_OUT, which strobes the
// result. busy is low again in S_OUT, so a new word can be taken there, but
// not while one is in S_CMP or S_UPD. the receiver cannot stall the queue.
// synchronous active-low reset empties the queue; slot contents need none.
module sorted_point_priority_queue_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  spq_pkg::in_word_t  in_word,
  output logic               out_valid,
  output spq_pkg::out_word_t out_word
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [spq_pkg::CNT_W-1:0]   count_r, count_nxt;
  spq_pkg::in_word_t           cmd_r;
  logic [spq_pkg::STAT_W-1:0]  stat_r, stat_nxt;
  spq_pkg::point_t             pop_r, pop_nxt;

  spq_pkg::cell_ctl_t          ctl;
  spq_pkg::point_t             cell_pt [spq_pkg::CAPACITY];
  logic [spq_pkg::CAPACITY-1:0] ge_v, eq_v, valid_v;

  logic accept, is_full, is_emp, dup, upd;

  assign accept  = start && !busy;
  assign busy    = (state_r == S_CMP) || (state_r == S_UPD);
  assign is_full = (count_r == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
  assign is_emp  = (count_r == '0);
  assign dup     = |eq_v;
  assign upd     = (state_r == S_UPD);

  always_comb begin
    ctl.cmp_en = (state_r == S_CMP);
    ctl.pnt.x  = cmd_r.point_x;
    ctl.pnt.y  = cmd_r.point_y;
    ctl.ins    = upd && (cmd_r.operation == spq_pkg::OP_PUSH) && !is_full && !dup;
    ctl.shift  = upd && (cmd_r.operation == spq_pkg::OP_POP) && !is_emp;
  end

  genvar gi;
  generate
    for (gi = 0; gi < spq_pkg::CAPACITY; gi++) begin : g_cell
      spq_pkg::point_t lp, rp;
      logic            lg;
      assign valid_v[gi] = (spq_pkg::CNT_W'(gi) < count_r);
      if (gi == 0) begin : g_first
        assign lp = cell_pt[gi];
        assign lg = 1'b0;
      end else begin : g_mid
        assign lp = cell_pt[gi-1];
        assign lg = ge_v[gi-1];
      end
      if (gi == spq_pkg::CAPACITY - 1) begin : g_last
        assign rp = cell_pt[gi];
      end else begin : g_inner
        assign rp = cell_pt[gi+1];
      end
      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .slot_valid (valid_v[gi]),
        .left_pt    (lp),
        .left_ge    (lg),
        .right_pt   (rp),
        .pt         (cell_pt[gi]),
        .ge         (ge_v[gi]),
        .eq         (eq_v[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    stat_nxt  = stat_r;
    pop_nxt   = pop_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        state_nxt = S_OUT;
        pop_nxt   = '0;
        if (cmd_r.operation == spq_pkg::OP_PUSH) begin
          if (is_full) begin
            stat_nxt = spq_pkg::STAT_FULL;
          end else if (dup) begin
            stat_nxt = spq_pkg::STAT_DUP;
          end else begin
            stat_nxt  = spq_pkg::STAT_OK;
            count_nxt = count_r + 1'b1;
          end
        end else begin
          if (is_emp) begin
            stat_nxt = spq_pkg::STAT_EMPTY;
          end else begin
            stat_nxt  = spq_pkg::STAT_OK;
            pop_nxt   = cell_pt[0];
            count_nxt = count_r - 1'b1;
          end
        end
      end
      S_OUT: begin
        state_nxt = accept ? S_CMP : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_word;
    end
    stat_r <= stat_nxt;
    pop_r  <= pop_nxt;
  end

  assign out_valid = (state_r == S_OUT);

  always_comb begin
    out_word.status       = stat_r;
    out_word.popped_x     = pop_r.x;
    out_word.popped_y     = pop_r.y;
    out_word.top_x        = is_emp ? '0 : cell_pt[0].x;
    out_word.top_y        = is_emp ? '0 : cell_pt[0].y;
    out_word.stored_count = spq_pkg::COUNT_W'(count_r);
    out_word.is_empty     = is_emp;
  end

endmodule
